@@ rtl/core/b64d_pkg.sv @@
// Shared types and character constants for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;

  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam int CountWidth = 16;
  localparam int DataWidth  = 32;

  // Register word addresses on the configuration port.
  localparam logic REG_MAX_OUTPUT_BYTES = 1'b0;

  typedef struct packed {
    logic       digit;   // character belongs to the alphabet
    logic       pad;     // '=' or '_'
    logic [5:0] sextet;  // value when digit is set
  } char_class_t;

endpackage

`default_nettype wire

@@ rtl/core/b64d_char_class.sv @@
// Character classifier: maps one ASCII character to its base64 digit or pad flag.
`default_nettype none

module b64d_char_class (
  input  wire logic [7:0]           ch,
  output b64d_pkg::char_class_t     cls
);
  import b64d_pkg::*;

  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;

  assign upper_off = ch - CHAR_UPPER_A;
  assign lower_off = ch - CHAR_LOWER_A + LOWER_BASE;
  assign digit_off = ch - CHAR_ZERO + DIGIT_BASE;

  always_comb begin
    cls.digit  = 1'b1;
    cls.pad    = 1'b0;
    cls.sextet = '0;
    if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      cls.sextet = upper_off[5:0];
    end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      cls.sextet = lower_off[5:0];
    end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cls.sextet = digit_off[5:0];
    end else if (ch == CHAR_PLUS) begin
      cls.sextet = SEXTET_PLUS;
    end else if (ch inside {CHAR_SLASH, CHAR_DASH}) begin
      cls.sextet = SEXTET_SLASH;
    end else begin
      cls.digit = 1'b0;
      cls.pad   = (ch inside {CHAR_EQUAL, CHAR_UNDER});
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder: input stage, group decoder, result stage, APB.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata[7:0] input_char, s_tlast last_char
//   m_*       out  m_tvalid/m_tready  m_tdata data_byte/decode_error/byte_count,
//                                     m_tlast done_res, m_tuser byte_valid
//   apb       in   psel/penable       register 0 max_output_bytes at byte address 0
//
// Every request gives exactly one result, held first in the input register and then
// in the output register. One request is taken per cycle while m_tready does not stall
// the output: the input register feeds the character classifier and group decoder,
// whose result lands in the output register. The per-string state advances when a
// request moves from input to output register. A stall on m_tready holds the output
// register, then the input register, and then drops s_tready. Reset (rst, synchronous)
// empties both stages, clears the string state and restores max_output_bytes to 65535.
`default_nettype none

module base64_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input_char [7:0]
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // data_byte [7:0], decode_error [8], byte_count [24:9], zeros [31:25]
  output logic [b64d_pkg::DataWidth-1:0] m_tdata,
  // byte_valid [0]
  output logic             m_tuser,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } group_pos_t;

  // Configuration register.
  logic [CountWidth-1:0] max_output_bytes;

  // Input stage.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // Per-string state.
  group_pos_t            pos;
  logic [5:0]            prev_sextet;
  logic                  pad_seen;
  logic                  failed;
  logic [CountWidth-1:0] count;

  group_pos_t            pos_next;
  logic [5:0]            prev_sextet_next;
  logic                  pad_seen_next;
  logic                  failed_next;
  logic [CountWidth-1:0] count_next;

  // Decoder results.
  logic                  emit_try;
  logic                  emit;
  logic [7:0]            cand_byte;
  logic [7:0]            res_byte;
  logic                  res_error;
  logic [CountWidth-1:0] res_count;

  char_class_t cls;
  logic        advance;
  logic        cfg_write;

  // Move a request forward when the output register is empty or is being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_OUTPUT_BYTES);
  assign prdata    = (paddr[2] == REG_MAX_OUTPUT_BYTES) ?
                     {{(32-CountWidth){1'b0}}, max_output_bytes} : 32'd0;

  b64d_char_class u_char_class (
    .ch  (in_char),
    .cls (cls)
  );

  // Group decoder: one character against the string state.
  always_comb begin
    pos_next         = pos;
    prev_sextet_next = prev_sextet;
    pad_seen_next    = pad_seen;
    failed_next      = failed;
    count_next       = count;
    emit_try         = 1'b0;
    emit             = 1'b0;
    cand_byte        = '0;

    if (!failed) begin
      case (pos)
        POS_FIRST: begin
          // A digit after a completed padded group is an error.
          if (pad_seen || !cls.digit) begin
            failed_next = 1'b1;
          end else begin
            prev_sextet_next = cls.sextet;
            pos_next         = POS_SECOND;
          end
        end
        POS_SECOND: begin
          if (!cls.digit) begin
            failed_next = 1'b1;
          end else begin
            emit_try         = 1'b1;
            cand_byte        = {prev_sextet, cls.sextet[5:4]};
            prev_sextet_next = cls.sextet;
            pos_next         = POS_THIRD;
          end
        end
        POS_THIRD: begin
          if (cls.pad) begin
            pad_seen_next = 1'b1;
            pos_next      = POS_FOURTH;
          end else if (!cls.digit) begin
            failed_next = 1'b1;
          end else begin
            emit_try         = 1'b1;
            cand_byte        = {prev_sextet[3:0], cls.sextet[5:2]};
            prev_sextet_next = cls.sextet;
            pos_next         = POS_FOURTH;
          end
        end
        POS_FOURTH: begin
          if (cls.pad) begin
            pad_seen_next = 1'b1;
            pos_next      = POS_FIRST;
          end else if (pad_seen || !cls.digit) begin
            // A digit after a pad in the third place.
            failed_next = 1'b1;
          end else begin
            emit_try  = 1'b1;
            cand_byte = {prev_sextet[1:0], cls.sextet};
            pos_next  = POS_FIRST;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase

      // Capacity check: drop the byte and fail once the buffer is full.
      if (emit_try) begin
        if (count < max_output_bytes) begin
          emit       = 1'b1;
          count_next = count + 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    // A string that ends with a lone character in its last group fails.
    if (in_last && !failed_next && pos_next == POS_SECOND) begin
      failed_next = 1'b1;
    end

    res_byte  = emit ? cand_byte : 8'd0;
    res_error = in_last && failed_next;
    res_count = (in_last && !failed_next) ? count_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= '1;
      in_valid         <= 1'b0;
      m_tvalid         <= 1'b0;
      pos              <= POS_FIRST;
      prev_sextet      <= '0;
      pad_seen         <= 1'b0;
      failed           <= 1'b0;
      count            <= '0;
    end else begin
      if (cfg_write) begin
        max_output_bytes <= pwdata[CountWidth-1:0];
      end

      // Input register: load on accept, empty when its request advances.
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_char  <= s_tdata;
        in_last  <= s_tlast;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        m_tvalid <= 1'b1;
        m_tuser  <= emit;
        m_tlast  <= in_last;
        m_tdata  <= {{(DataWidth-9-CountWidth){1'b0}}, res_count, res_error, res_byte};
        // Return to the start state after the last character of a string.
        if (in_last) begin
          pos         <= POS_FIRST;
          prev_sextet <= '0;
          pad_seen    <= 1'b0;
          failed      <= 1'b0;
          count       <= '0;
        end else begin
          pos         <= pos_next;
          prev_sextet <= prev_sextet_next;
          pad_seen    <= pad_seen_next;
          failed      <= failed_next;
          count       <= count_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // An error result never carries a byte count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[8+CountWidth:9] == '0)
    else $error("error result carries a nonzero byte count");

  // Status fields stay clear on results that do not end a string.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[8] && m_tdata[8+CountWidth:9] == '0)
    else $error("status reported before the end of the string");

  // String state is back at its start after the last character moves on.
  assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> pos == POS_FIRST && count == '0 && !failed && !pad_seen)
    else $error("string state not cleared after the last character");

  // A full input stage with a stalled output refuses new requests.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are stalled");

endmodule

`default_nettype wire

@@ dv/base64_stream_decoder_tb.sv @@
// Self-checking testbench for the base64 stream decoder: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
  import b64d_pkg::*;

  // One character request on the input stream.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  // One decoder result, fields in the order they are compared.
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        done;
    logic        decode_error;
    logic [15:0] byte_count;
  } decode_result_t;

  logic        clk;
  logic        rst;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        s_tvalid;
  logic        s_tready;
  logic [DataWidth-1:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  base64_stream_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Requests waiting to be driven, and decoded results still owed by the block.
  char_req_t      char_queue[$];
  decode_result_t pending_decodes[$];

  int err_count   = 0;
  int src_idle    = 16;  // percent of cycles the sender holds off
  int sink_idle   = 16;  // percent of cycles the receiver stalls
  int queued_chars;
  logic req_accepted = 1'b0;

  // Predictor state: one string in flight plus the capacity register.
  logic [1:0]  grp_pos;
  logic [5:0]  prev_sextet;
  logic        pad_flag;
  logic        str_failed;
  logic [15:0] out_count;
  logic [15:0] cap_bytes;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Timeout: far beyond the slowest correct run of about 2000 requests.
  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Sextet value of a character, or -1 when it is outside both alphabets.
  function automatic int char_sextet(logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A) + 26;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO) + 52;
    if (c == CHAR_PLUS) return int'(SEXTET_PLUS);
    if (c == CHAR_SLASH || c == CHAR_DASH) return int'(SEXTET_SLASH);
    return -1;
  endfunction

  function automatic logic is_pad_char(logic [7:0] c);
    return c == CHAR_EQUAL || c == CHAR_UNDER;
  endfunction

  task automatic clear_string();
    grp_pos     = 2'd0;
    prev_sextet = 6'd0;
    pad_flag    = 1'b0;
    str_failed  = 1'b0;
    out_count   = 16'd0;
  endtask

  // Advance the string state by one accepted character and queue the result it owes.
  task automatic decode_char(logic [7:0] c, logic last);
    decode_result_t res;
    int             d;
    logic [5:0]     sx;
    logic [7:0]     cand;
    logic           want;
    logic           valid;
    logic [7:0]     b;
    d     = char_sextet(c);
    sx    = d[5:0];
    cand  = 8'd0;
    want  = 1'b0;
    valid = 1'b0;
    b     = 8'd0;
    if (!str_failed) begin
      case (grp_pos)
        2'd0: begin
          if (pad_flag || d < 0) begin
            str_failed = 1'b1;
          end else begin
            prev_sextet = sx;
            grp_pos     = 2'd1;
          end
        end
        2'd1: begin
          if (d < 0) begin
            str_failed = 1'b1;
          end else begin
            cand        = {prev_sextet, sx[5:4]};
            want        = 1'b1;
            prev_sextet = sx;
            grp_pos     = 2'd2;
          end
        end
        2'd2: begin
          if (is_pad_char(c)) begin
            pad_flag = 1'b1;
            grp_pos  = 2'd3;
          end else if (d < 0) begin
            str_failed = 1'b1;
          end else begin
            cand        = {prev_sextet[3:0], sx[5:2]};
            want        = 1'b1;
            prev_sextet = sx;
            grp_pos     = 2'd3;
          end
        end
        default: begin
          if (is_pad_char(c)) begin
            pad_flag = 1'b1;
            grp_pos  = 2'd0;
          end else if (pad_flag || d < 0) begin
            str_failed = 1'b1;
          end else begin
            cand    = {prev_sextet[1:0], sx};
            want    = 1'b1;
            grp_pos = 2'd0;
          end
        end
      endcase
      // Capacity: a byte past the limit fails the string and is dropped.
      if (want) begin
        if (out_count >= cap_bytes) begin
          str_failed = 1'b1;
        end else begin
          out_count = out_count + 16'd1;
          valid     = 1'b1;
          b         = cand;
        end
      end
    end
    // A lone character in the final group cannot form a byte.
    if (last && !str_failed && grp_pos == 2'd1) str_failed = 1'b1;
    res.byte_valid   = valid;
    res.data_byte    = valid ? b : 8'd0;
    res.done         = last;
    res.decode_error = last && str_failed;
    res.byte_count   = (last && !str_failed) ? out_count : 16'd0;
    pending_decodes.push_back(res);
    if (last) clear_string();
  endtask

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    req_accepted <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[7:0], m_tlast, m_tdata[8], m_tdata[24:9]};
      if (pending_decodes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result valid=%0b byte=%h done=%0b err=%0b count=%0d",
                   $realtime, got.byte_valid, got.data_byte, got.done,
                   got.decode_error, got.byte_count);
      end else begin
        want = pending_decodes.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $write("%0t: mismatch exp valid=%0b byte=%h done=%0b err=%0b count=%0d",
                   $realtime, want.byte_valid, want.data_byte, want.done,
                   want.decode_error, want.byte_count);
            $display(" got valid=%0b byte=%h done=%0b err=%0b count=%0d",
                     got.byte_valid, got.data_byte, got.done, got.decode_error,
                     got.byte_count);
          end
        end
      end
    end
  end

  // Driver: present the next request after acceptance or an idle cycle, stall the output.
  always @(negedge clk) begin
    char_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_accepted) begin
      if (char_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
        nxt = char_queue.pop_front();
        s_tdata  <= nxt.ch;
        s_tlast  <= nxt.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(99) >= sink_idle);
  end

  task automatic queue_char(logic [7:0] c, logic last);
    char_queue.push_back('{ch: c, last: last});
    queued_chars++;
  endtask

  task automatic queue_text(string t);
    for (int i = 0; i < t.len(); i++) queue_char(t[i], i == t.len() - 1);
  endtask

  // Random digit from either alphabet; 63 picks the standard or the url-safe form.
  function automatic logic [7:0] any_digit();
    int v;
    v = $urandom_range(63);
    if (v < 26) return CHAR_UPPER_A + 8'(v);
    if (v < 52) return CHAR_LOWER_A + 8'(v - 26);
    if (v < 62) return CHAR_ZERO + 8'(v - 52);
    if (v == 62) return CHAR_PLUS;
    return $urandom_range(1) ? CHAR_SLASH : CHAR_DASH;
  endfunction

  function automatic logic [7:0] pad_char();
    return $urandom_range(1) ? CHAR_EQUAL : CHAR_UNDER;
  endfunction

  // Queue one random string: mostly well formed, some corrupted, some noise.
  task automatic add_random_string();
    logic [7:0] s[$];
    int         kind;
    int         groups;
    int         tail;
    int         sel;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 8)) begin
        sel = $urandom_range(3);
        if (sel < 2) s.push_back(any_digit());
        else if (sel == 2) s.push_back(pad_char());
        else s.push_back(8'($urandom_range(255)));
      end
    end else begin
      // Mostly short strings so small capacities are crossed; now and then a long one.
      groups = ($urandom_range(9) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
      tail   = $urandom_range(2);
      if (groups == 0 && tail == 0) tail = 1 + $urandom_range(1);
      repeat (4 * groups) s.push_back(any_digit());
      if (tail == 1) begin
        s.push_back(any_digit());
        s.push_back(any_digit());
        sel = $urandom_range(2);
        if (sel >= 1) s.push_back(pad_char());
        if (sel == 2) s.push_back(pad_char());
      end else if (tail == 2) begin
        repeat (3) s.push_back(any_digit());
        if ($urandom_range(1)) s.push_back(pad_char());
      end
      if (kind >= 70) begin
        case ($urandom_range(3))
          0: s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
          1: s[$urandom_range(s.size() - 1)] = pad_char();
          2: s.push_back(any_digit());
          default: begin
            s.push_back(pad_char());
            s.push_back(any_digit());
          end
        endcase
      end
    end
    foreach (s[i]) queue_char(s[i], i == s.size() - 1);
  endtask

  task automatic queue_random(int n_chars);
    int target;
    target = queued_chars + n_chars;
    while (queued_chars < target) add_random_string();
  endtask

  // Hold the sender until every request is out and every result is back.
  task automatic drain();
    while (char_queue.size() != 0 || s_tvalid || pending_decodes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == 3'(4 * REG_MAX_OUTPUT_BYTES)) cap_bytes = value[15:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_capacity(logic [15:0] value);
    reg_write(3'(4 * REG_MAX_OUTPUT_BYTES), {16'd0, value});
  endtask

  initial begin
    rst          = 1'b1;
    s_tdata      = 8'd0;
    s_tlast      = 1'b0;
    s_tvalid     = 1'b0;
    m_tready     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 3'd0;
    pwdata       = 32'd0;
    queued_chars = 0;
    cap_bytes    = 16'hFFFF;
    clear_string();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed strings at the reset capacity.
    queue_text("TWFu");              // full group, three bytes
    queue_text("TQ==");              // standard padding
    queue_text("TWE_");              // url-safe pad in the last place
    queue_text("+/-_");              // 62, both forms of 63, url pad
    queue_text("TQ");                // truncated group of two
    queue_text("TQ=");               // pad in third place, ends there
    queue_char(8'h00, 1'b1);         // lone invalid character
    queue_char("T", 1'b0);
    queue_char(8'hFF, 1'b1);         // invalid digit in second place
    queue_text("TQ=A");              // pad then a digit in fourth place
    queue_text("Tz9");               // truncated group of three
    queue_text("TWE=QQ");            // digits after padding
    queue_text("T");                 // a single-character group fails
    drain();

    // Zero capacity: the first byte of any string fails it.
    set_capacity(16'd0);
    queue_text("TWFu");
    queue_random(150);
    drain();

    set_capacity(16'd1);
    queue_random(250);
    drain();

    set_capacity(16'd4);
    queue_random(300);
    drain();

    set_capacity(16'($urandom_range(2, 40)));
    queue_random(350);
    drain();

    // Full capacity: a stretch with no idling, a pause until all results are in, then more.
    set_capacity(16'hFFFF);
    src_idle  = 0;
    sink_idle = 0;
    queue_random(300);
    drain();
    src_idle  = 16;
    sink_idle = 16;
    queue_random(300);
    drain();

    err_count += pending_decodes.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
